>>> src/websocket_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the WebSocket frame deframer
// Concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types, codes and constants of the deframer modules.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_ERR  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_EMPTY      = 2'd1,
    KIND_ERROR      = 2'd2,
    KIND_INCOMPLETE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_RESERVED   = 3'd1,
    ERR_OPCODE     = 3'd2,
    ERR_FRAGMENTED = 3'd3,
    ERR_UNMASKED   = 3'd4,
    ERR_LEN_TOP    = 3'd5,
    ERR_CTRL_LEN   = 3'd6
  } err_code_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] CTRL_MAX_LEN  = 7'd125;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;

  localparam int unsigned TDATA_W = 88;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        masked;
    logic        last;
    logic        incomplete;
    err_code_e   err;
    logic [63:0] frame_bytes;
  } wsdf_res_t;

endpackage

>>> src/wsdf_parse.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer parser
// Header and payload state machine; one stream byte in, at most one result out.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsdf_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [7:0]         in_byte_i,
  input  logic               buffer_end_i,
  input  logic               mask_req_i,
  output logic               res_valid_o,
  output wsdf_pkg::wsdf_res_t res_o
);
  import wsdf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [62:0] pay_left_q, pay_left_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [63:0] total_q, total_d;
  logic        err_q, err_d;
  err_code_e   err_code_q, err_code_d;
  logic        data_start;

  function automatic logic known_op(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BIN ||
           op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  function automatic logic control_op(input logic [3:0] op);
    return op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  always_comb begin
    logic [63:0] len_new;
    logic [7:0]  key_byte;
    logic        finish_hdr;
    logic        do_start;
    logic        do_wait;
    logic        do_fail;
    err_code_e   fail_code;

    phase_d    = phase_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    ext_left_d = ext_left_q;
    len_d      = len_q;
    key_d      = key_q;
    pay_left_d = pay_left_q;
    key_idx_d  = key_idx_q;
    total_d    = total_q;
    err_d      = err_q;
    err_code_d = err_code_q;

    len_new    = {len_q[55:0], in_byte_i};
    key_byte   = 8'h00;
    finish_hdr = 1'b0;
    do_start   = 1'b0;
    do_wait    = 1'b0;
    do_fail    = 1'b0;
    fail_code  = ERR_NONE;

    res_valid_o = 1'b0;
    res_o       = '0;

    if (acc_i) begin
      if (err_q) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_ERROR;
        res_o.err   = err_code_q;
      end else begin
        total_d = total_q + 64'd1;
        unique case (phase_q)
          PH_HDR1: begin
            mask_d = in_byte_i[7];
            if (mask_req_i && !in_byte_i[7]) begin
              do_fail   = 1'b1;
              fail_code = ERR_UNMASKED;
            end else begin
              key_d     = '0;
              key_idx_d = '0;
              len_d     = '0;
              if (in_byte_i[6:0] >= LEN_EXT16) begin
                ext_left_d = (in_byte_i[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                phase_d    = PH_EXT;
                do_wait    = 1'b1;
              end else begin
                pay_left_d = {56'd0, in_byte_i[6:0]};
                finish_hdr = 1'b1;
              end
            end
          end
          PH_EXT: begin
            len_d      = len_new;
            ext_left_d = ext_left_q - 4'd1;
            if (ext_left_d != '0) begin
              do_wait = 1'b1;
            end else if (len_new[63]) begin
              do_fail   = 1'b1;
              fail_code = ERR_LEN_TOP;
            end else if (control_op(opcode_q) &&
                         (len_new[62:7] != '0 || len_new[6:0] > CTRL_MAX_LEN)) begin
              do_fail   = 1'b1;
              fail_code = ERR_CTRL_LEN;
            end else begin
              pay_left_d = len_new[62:0];
              finish_hdr = 1'b1;
            end
          end
          PH_KEY: begin
            key_d     = {key_q[23:0], in_byte_i};
            key_idx_d = key_idx_q + 2'd1;
            if (key_idx_d != '0) begin
              do_wait = 1'b1;
            end else begin
              do_start = 1'b1;
            end
          end
          PH_DATA: begin
            unique case (key_idx_q)
              2'd0:    key_byte = key_q[31:24];
              2'd1:    key_byte = key_q[23:16];
              2'd2:    key_byte = key_q[15:8];
              default: key_byte = key_q[7:0];
            endcase
            key_idx_d   = key_idx_q + 2'd1;
            pay_left_d  = pay_left_q - 63'd1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_DATA;
            res_o.data  = in_byte_i ^ key_byte;
            if (pay_left_q == 63'd1) begin
              phase_d           = PH_HDR0;
              res_o.last        = 1'b1;
              res_o.frame_bytes = total_d;
            end else begin
              res_o.incomplete = buffer_end_i;
            end
          end
          default: begin
            // Header byte zero; also covers the idle phase after an empty frame.
            total_d  = 64'd1;
            opcode_d = in_byte_i[3:0];
            mask_d   = 1'b0;
            if (in_byte_i[6:4] != '0) begin
              do_fail   = 1'b1;
              fail_code = ERR_RESERVED;
            end else if (!known_op(in_byte_i[3:0])) begin
              do_fail   = 1'b1;
              fail_code = ERR_OPCODE;
            end else if (!in_byte_i[7] || in_byte_i[3:0] == OP_CONT) begin
              do_fail   = 1'b1;
              fail_code = ERR_FRAGMENTED;
            end else begin
              phase_d = PH_HDR1;
              do_wait = 1'b1;
            end
          end
        endcase

        if (finish_hdr) begin
          if (mask_d) begin
            phase_d   = PH_KEY;
            key_idx_d = '0;
            do_wait   = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end

        if (do_start) begin
          key_idx_d = '0;
          if (pay_left_d == '0) begin
            phase_d           = PH_HDR0;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_EMPTY;
            res_o.last        = 1'b1;
            res_o.frame_bytes = total_d;
          end else begin
            phase_d = PH_DATA;
            do_wait = 1'b1;
          end
        end

        if (do_wait && buffer_end_i) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_INCOMPLETE;
          res_o.incomplete = 1'b1;
        end

        if (do_fail) begin
          err_d       = 1'b1;
          err_code_d  = fail_code;
          phase_d     = PH_ERR;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ERROR;
          res_o.err   = fail_code;
        end
      end
    end

    // Results report the frame fields as they stand after this byte.
    res_o.opcode = opcode_d;
    res_o.masked = mask_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      opcode_q   <= '0;
      mask_q     <= 1'b0;
      ext_left_q <= '0;
      len_q      <= '0;
      key_q      <= '0;
      pay_left_q <= '0;
      key_idx_q  <= '0;
      total_q    <= '0;
      err_q      <= 1'b0;
      err_code_q <= ERR_NONE;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      mask_q     <= mask_d;
      ext_left_q <= ext_left_d;
      len_q      <= len_d;
      key_q      <= key_d;
      pay_left_q <= pay_left_d;
      key_idx_q  <= key_idx_d;
      total_q    <= total_d;
      err_q      <= err_d;
      err_code_q <= err_code_d;
    end
  end

  assign data_start = phase_q != PH_DATA && phase_d == PH_DATA;

  `WSDF_ASSERT_NEXT(a_err_sticky, err_q, err_q && err_code_q != ERR_NONE, "error lost")
  `WSDF_ASSERT_SAME(a_data_left, phase_q == PH_DATA && !err_q, pay_left_q != '0, "empty payload")
  `WSDF_ASSERT_SAME(a_ext_left, phase_q == PH_EXT && !err_q, ext_left_q != '0, "no length bytes")
  `WSDF_ASSERT_NEXT(a_key_start, data_start, key_idx_q == 2'd0, "payload began off key byte zero")
  `WSDF_ASSERT_SAME(a_last_kind, res_valid_o && res_o.last, res_o.kind <= KIND_EMPTY, "stray last")

endmodule

>>> src/wsdf_skid.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer output stage
// Result register with one skid entry, so the input waits only while the skid entry is full.
// ----------------------------------------------------------------------------
module wsdf_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wsdf_pkg::wsdf_res_t in_res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsdf_pkg::wsdf_res_t out_res_o
);
  import wsdf_pkg::*;

  logic      out_valid_q, out_valid_d;
  wsdf_res_t out_res_q, out_res_d;
  logic      skid_valid_q, skid_valid_d;
  wsdf_res_t skid_res_q, skid_res_d;
  logic      out_free;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // Input is held off while the skid entry is full, so only it moves.
        out_valid_d  = 1'b1;
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_res_d   = in_res_i;
      end
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_res_d   = in_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

endmodule

>>> src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_tvalid/s_tready  stream byte, buffer-end flag
//  m_*       out        m_tvalid/m_tready  result kind, payload byte, frame info
//  cfg_*     in         cfg_we             mask-required flag
//
//  One item is taken per clock while s_tready is high; its result, if any, goes to
//  the output register, or to the skid entry while the output is stalled.
//  Reset leaves the mask-required flag set and the parser waiting for header byte zero.
//  A stalled output holds its result; one more result parks in a skid entry,
//  and only then does s_tready drop.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [7:0]                    s_tdata_i,  // [7:0] in_byte
  input  logic                          s_tuser_i,  // [0] buffer_end
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [7:0] data, [11:8] opcode, [12] masked, [13] incomplete,
  // [16:14] error_code, [80:17] frame_bytes, [87:81] zero
  output logic [wsdf_pkg::TDATA_W-1:0]  m_tdata_o,
  output logic [1:0]                    m_tuser_o,  // [1:0] kind
  output logic                          m_tlast_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i
);
  import wsdf_pkg::*;

  logic      mask_req_q;
  logic      acc;
  logic      res_valid;
  wsdf_res_t res;
  wsdf_res_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_req_q <= 1'b1;
    end else if (cfg_we_i) begin
      mask_req_q <= cfg_wdata_i;
    end
  end

  assign acc = s_tvalid_i && s_tready_o;

  wsdf_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .in_byte_i    (s_tdata_i),
    .buffer_end_i (s_tuser_i),
    .mask_req_i   (mask_req_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsdf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (s_tready_o),
    .in_res_i    (res),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_res_o   (out_res)
  );

  assign m_tdata_o = {7'd0, out_res.frame_bytes, out_res.err, out_res.incomplete,
                      out_res.masked, out_res.opcode, out_res.data};
  assign m_tuser_o = out_res.kind;
  assign m_tlast_o = out_res.last;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams frame bytes into the deframer with random burst gaps and output
// stalls. A behavioral deframer predicts each result, and every result item is
// checked field by field. The run ends with one latched protocol error.
// ----------------------------------------------------------------------------
module testbench;
  import wsdf_pkg::*;

  typedef enum logic [1:0] {LEN_SHORT, LEN_16, LEN_64} len_form_e;
  typedef enum logic [1:0] {BE_NONE, BE_ALL, BE_RANDOM} be_mode_e;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_TOGGLE} ready_mode_e;

  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam int         STALL_LIMIT = 5000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  logic [7:0]          s_tdata_i   = '0;
  logic                s_tuser_i   = 1'b0;
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic [TDATA_W-1:0]  m_tdata_o;
  logic [1:0]          m_tuser_o;
  logic                m_tlast_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;

  // Deframer state as predicted from the accepted bytes.
  logic        mask_req_q     = 1'b1;
  phase_e      fr_phase       = PH_HDR0;
  logic [3:0]  fr_opcode      = '0;
  logic        fr_masked      = 1'b0;
  logic [3:0]  fr_ext_left    = '0;
  logic [63:0] fr_len         = '0;
  logic [31:0] fr_key         = '0;
  logic [62:0] fr_left        = '0;
  logic [1:0]  fr_key_idx     = '0;
  logic [63:0] fr_total       = '0;
  logic        fr_err_latched = 1'b0;
  err_code_e   fr_err         = ERR_NONE;

  wsdf_res_t   expected_results[$];
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  int          ready_cycle = 0;
  ready_mode_e ready_mode  = RDY_ALWAYS;

  websocket_frame_deframer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit is_control(input logic [3:0] op);
    return op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  function automatic bit is_known(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BIN || is_control(op);
  endfunction

  function automatic wsdf_res_t frame_result(input kind_e kind, input logic [7:0] data,
                                             input logic last, input logic incomplete,
                                             input err_code_e err, input logic [63:0] nbytes);
    wsdf_res_t r;
    r.kind        = kind;
    r.data        = data;
    r.opcode      = fr_opcode;
    r.masked      = fr_masked;
    r.last        = last;
    r.incomplete  = incomplete;
    r.err         = err;
    r.frame_bytes = nbytes;
    return r;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] b, input logic be,
                                      output wsdf_res_t res);
    bit        hdr_done;
    bit        start_payload;
    err_code_e fault;
    logic [7:0] k;
    hdr_done      = 1'b0;
    start_payload = 1'b0;
    fault         = ERR_NONE;
    if (fr_err_latched) begin
      res = frame_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, fr_err, 64'd0);
      return 1'b1;
    end
    fr_total = fr_total + 64'd1;
    case (fr_phase)
      PH_HDR1: begin
        fr_masked = b[7];
        if (mask_req_q && !b[7]) begin
          fault = ERR_UNMASKED;
        end else begin
          fr_key     = '0;
          fr_key_idx = '0;
          fr_len     = '0;
          if (b[6:0] >= LEN_EXT16) begin
            fr_ext_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            fr_phase    = PH_EXT;
          end else begin
            fr_left  = 63'(b[6:0]);
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        fr_len      = {fr_len[55:0], b};
        fr_ext_left = fr_ext_left - 4'd1;
        if (fr_ext_left == 4'd0) begin
          if (fr_len[63]) begin
            fault = ERR_LEN_TOP;
          end else if (is_control(fr_opcode) && fr_len > 64'(CTRL_MAX_LEN)) begin
            fault = ERR_CTRL_LEN;
          end else begin
            fr_left  = fr_len[62:0];
            hdr_done = 1'b1;
          end
        end
      end
      PH_KEY: begin
        fr_key     = {fr_key[23:0], b};
        fr_key_idx = fr_key_idx + 2'd1;
        if (fr_key_idx == 2'd0) start_payload = 1'b1;
      end
      PH_DATA: begin
        // The key is applied most significant byte first.
        k          = fr_key[8 * (3 - fr_key_idx) +: 8];
        fr_key_idx = fr_key_idx + 2'd1;
        fr_left    = fr_left - 63'd1;
        if (fr_left == 63'd0) begin
          fr_phase = PH_HDR0;
          res = frame_result(KIND_DATA, b ^ k, 1'b1, 1'b0, ERR_NONE, fr_total);
        end else begin
          res = frame_result(KIND_DATA, b ^ k, 1'b0, be, ERR_NONE, 64'd0);
        end
        return 1'b1;
      end
      default: begin
        fr_total  = 64'd1;
        fr_opcode = b[3:0];
        fr_masked = 1'b0;
        if (b[6:4] != 3'b000) fault = ERR_RESERVED;
        else if (!is_known(b[3:0])) fault = ERR_OPCODE;
        else if (!b[7] || b[3:0] == OP_CONT) fault = ERR_FRAGMENTED;
        else fr_phase = PH_HDR1;
      end
    endcase
    if (fault != ERR_NONE) begin
      fr_err_latched = 1'b1;
      fr_err         = fault;
      fr_phase       = PH_ERR;
      res = frame_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, fault, 64'd0);
      return 1'b1;
    end
    if (hdr_done) begin
      if (fr_masked) begin
        fr_phase   = PH_KEY;
        fr_key_idx = '0;
      end else begin
        start_payload = 1'b1;
      end
    end
    if (start_payload) begin
      fr_key_idx = '0;
      if (fr_left == 63'd0) begin
        fr_phase = PH_HDR0;
        res = frame_result(KIND_EMPTY, 8'h00, 1'b1, 1'b0, ERR_NONE, fr_total);
        return 1'b1;
      end
      fr_phase = PH_DATA;
    end
    // Still inside a header: only the buffer end is reported.
    res = frame_result(KIND_INCOMPLETE, 8'h00, 1'b0, 1'b1, ERR_NONE, 64'd0);
    return be;
  endfunction

  function automatic string result_text(input wsdf_res_t r);
    return $sformatf("kind %0d data %h opcode %h masked %b last %b incomplete %b err %0d bytes %0d",
                     r.kind, r.data, r.opcode, r.masked, r.last, r.incomplete, r.err,
                     r.frame_bytes);
  endfunction

  always @(posedge clk_i) begin : monitor
    wsdf_res_t got;
    wsdf_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) mask_req_q = cfg_wdata_i;
      if (m_tvalid_o && m_tready_i) begin
        got.kind        = kind_e'(m_tuser_o);
        got.data        = m_tdata_o[7:0];
        got.opcode      = m_tdata_o[11:8];
        got.masked      = m_tdata_o[12];
        got.last        = m_tlast_o;
        got.incomplete  = m_tdata_o[13];
        got.err         = err_code_e'(m_tdata_o[16:14]);
        got.frame_bytes = m_tdata_o[80:17];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", result_text(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch");
              $display("  expected %s", result_text(want));
              $display("  actual   %s", result_text(got));
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        if (deframe_byte(s_tdata_i, s_tuser_i, want)) begin
          expected_results.insert(expected_results.size(), want);
        end
      end
      if ((m_tvalid_o && m_tready_i) || (s_tvalid_i && s_tready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("websocket_frame_deframer test failed");
        $finish;
      end
    end
  end

  // Receiver backpressure: the pattern switches periodically to a randomly picked mode.
  always @(posedge clk_i) begin
    ready_cycle++;
    if (ready_cycle % 128 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: m_tready_i <= 1'b1;
      RDY_MOSTLY: m_tready_i <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: m_tready_i <= ($urandom_range(0, 3) == 0);
      default:    m_tready_i <= ready_cycle[2];
    endcase
  end

  function automatic logic buffer_end_for(input be_mode_e mode);
    return mode == BE_ALL || (mode == BE_RANDOM && $urandom_range(0, 5) == 0);
  endfunction

  function automatic logic [3:0] any_frame_op();
    case ($urandom_range(0, 4))
      0:       return OP_TEXT;
      1:       return OP_BIN;
      2:       return OP_CLOSE;
      3:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic be);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick       = $urandom_range(0, 7);
      gap        = (pick < 3) ? 0 : (pick < 6) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tuser_i  <= be;
    do @(posedge clk_i); while (!s_tready_o);
    items_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input logic mask, input len_form_e form,
                            input logic [63:0] len, input logic [31:0] key,
                            input be_mode_e bmode);
    logic [6:0]  len7;
    logic [63:0] n;
    int          i;
    len7 = (form == LEN_SHORT) ? len[6:0] : (form == LEN_16) ? LEN_EXT16 : LEN_EXT64;
    send_byte({1'b1, 3'b000, op}, buffer_end_for(bmode));
    send_byte({mask, len7}, buffer_end_for(bmode));
    if (form == LEN_16) begin
      for (i = 1; i >= 0; i--) send_byte(len[8 * i +: 8], buffer_end_for(bmode));
    end else if (form == LEN_64) begin
      for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8], buffer_end_for(bmode));
    end
    if (mask) begin
      for (i = 3; i >= 0; i--) send_byte(key[8 * i +: 8], buffer_end_for(bmode));
    end
    for (n = 0; n < len; n++) send_byte(8'($urandom_range(0, 255)), buffer_end_for(bmode));
  endtask

  task automatic send_random_frames(input int byte_goal, input bit allow_unmasked);
    logic [3:0]  op;
    logic        mask;
    len_form_e   form;
    logic [63:0] len;
    bit          short_payload;
    int          first;
    int          pick;
    first = items_sent;
    while (items_sent - first < byte_goal) begin
      op            = any_frame_op();
      mask          = allow_unmasked ? 1'($urandom_range(0, 1)) : 1'b1;
      pick          = $urandom_range(0, 9);
      form          = (pick < 7) ? LEN_SHORT : (pick < 9) ? LEN_16 : LEN_64;
      short_payload = ($urandom_range(0, 3) != 0);
      // Payloads stay short so that many frames fit; 16-bit lengths reach past 125.
      if (form == LEN_16 && !short_payload && !is_control(op)) begin
        len = 64'($urandom_range(126, 300));
      end else begin
        len = short_payload ? 64'($urandom_range(0, 12)) : 64'($urandom_range(0, 125));
      end
      send_frame(op, mask, form, len, $urandom, BE_RANDOM);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    // Wait on the clock first, so the result of the last byte is already queued.
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // Header bytes without a buffer end give no result, so let the pipeline settle as well.
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mask_req(input logic value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_directed_masked();
    // Empty frame with every header byte flagged as buffer end, then a control
    // frame with a 16-bit length.
    send_frame(OP_TEXT, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, BE_ALL);
    send_frame(OP_PING, 1'b1, LEN_16, 64'd3, 32'h0000_0000, BE_ALL);
  endtask

  task automatic test_random_masked();
    send_random_frames(180, 1'b0);
  endtask

  task automatic test_unmasked_frames();
    write_mask_req(1'b0);
    send_frame(OP_PONG, 1'b0, LEN_SHORT, 64'd0, 32'h0, BE_NONE);
    send_frame(OP_TEXT, 1'b0, LEN_64, 64'd2, 32'h0, BE_RANDOM);
    send_frame(OP_CLOSE, 1'b1, LEN_SHORT, 64'd1, $urandom, BE_ALL);
    send_random_frames(180, 1'b1);
  endtask

  task automatic test_mask_required_again();
    write_mask_req(1'b1);
    send_random_frames(160, 1'b0);
  endtask

  // Errors stick until reset, so this runs last; the seed picks the error.
  task automatic test_sticky_error();
    err_code_e   pick;
    logic [3:0]  op;
    logic [15:0] len16;
    int          i;
    pick = err_code_e'($urandom_range(1, 6));
    case (pick)
      ERR_RESERVED: begin
        send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                   4'($urandom_range(0, 15))}, buffer_end_for(BE_RANDOM));
      end
      ERR_OPCODE: begin
        op = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        send_byte({1'($urandom_range(0, 1)), 3'b000, op}, buffer_end_for(BE_RANDOM));
      end
      ERR_FRAGMENTED: begin
        if ($urandom_range(0, 1) != 0) send_byte({1'b1, 3'b000, OP_CONT}, 1'b0);
        else send_byte({1'b0, 3'b000, any_frame_op()}, 1'b1);
      end
      ERR_UNMASKED: begin
        send_byte({1'b1, 3'b000, OP_TEXT}, 1'b0);
        send_byte({1'b0, 7'($urandom_range(0, 127))}, buffer_end_for(BE_RANDOM));
      end
      ERR_LEN_TOP: begin
        send_byte({1'b1, 3'b000, OP_BIN}, 1'b0);
        send_byte({1'b1, LEN_EXT64}, 1'b0);
        send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
        for (i = 0; i < 7; i++) send_byte(8'($urandom_range(0, 255)), buffer_end_for(BE_RANDOM));
      end
      default: begin
        op    = OP_CLOSE + 4'($urandom_range(0, 2));
        len16 = 16'($urandom_range(126, 65535));
        send_byte({1'b1, 3'b000, op}, 1'b0);
        send_byte({1'b1, LEN_EXT16}, 1'b0);
        send_byte(len16[15:8], 1'b0);
        send_byte(len16[7:0], buffer_end_for(BE_RANDOM));
      end
    endcase
    // Everything after the error must repeat the latched code.
    for (i = 0; i < 16; i++) send_byte(8'($urandom_range(0, 255)), buffer_end_for(BE_RANDOM));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_masked();
    test_random_masked();
    test_unmasked_frames();
    test_mask_required_again();
    test_sticky_error();
    wait_for_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("websocket_frame_deframer test passed");
    end else begin
      $display("websocket_frame_deframer test failed");
    end
    $finish;
  end

endmodule

>>> websocket_frame_deframer.f
+incdir+src
src/wsdf_pkg.sv
src/wsdf_parse.sv
src/wsdf_skid.sv
src/websocket_frame_deframer.sv
tb/testbench.sv
